[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define DSW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsw assertion failed");

// condition holds in the following cycle
`define DSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsw assertion failed");

`endif

[hdl/dsw_pkg.sv]
package dsw_pkg;

   localparam int WAYS_W   = 63;
   localparam int FACES_W  = 5;
   localparam int DICE_W   = 5;
   localparam int TARGET_W = 9;
   localparam int TOP_W    = FACES_W + DICE_W;

   localparam int MAX_FACES_DEFAULT = 16;
   localparam int MAX_DICE_DEFAULT  = 16;
   localparam int MAX_SUM_DEFAULT   = 256;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic first;
      logic tap_zero;
   } win_ctrl_type;

endpackage

[hdl/dsw_cell.sv]
module dsw_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [dsw_pkg::WAYS_W-1:0]  d_in,
   output logic [dsw_pkg::WAYS_W-1:0]  d_out
);

   logic [dsw_pkg::WAYS_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         val_ff <= d_in;
      end
   end

   assign d_out = val_ff;

endmodule

[hdl/dsw_window.sv]
module dsw_window #(
   parameter int MAX_FACES = dsw_pkg::MAX_FACES_DEFAULT,
   localparam int FW = $clog2(MAX_FACES)
) (
   input  logic                        clock,
   input  dsw_pkg::win_ctrl_type       ctrl,
   input  logic [FW-1:0]               tap_sel,
   input  logic [dsw_pkg::WAYS_W-1:0]  data,
   output logic [dsw_pkg::WAYS_W-1:0]  acc_next
);

   logic [dsw_pkg::WAYS_W-1:0] cell_q [MAX_FACES];
   logic [dsw_pkg::WAYS_W-1:0] acc_ff;
   logic [dsw_pkg::WAYS_W-1:0] acc_base;
   logic [dsw_pkg::WAYS_W-1:0] tap_val;

   // previous row entries, newest in cell 0
   for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
      if (i == 0) begin : g_head
         dsw_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (data),
            .d_out (cell_q[i])
         );
      end else begin : g_body
         dsw_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (cell_q[i-1]),
            .d_out (cell_q[i])
         );
      end
   end

   // entry leaving the window
   assign tap_val  = ctrl.tap_zero ? '0 : cell_q[tap_sel];
   assign acc_base = ctrl.first ? '0 : acc_ff;
   assign acc_next = acc_base + data - tap_val;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         acc_ff <= acc_next;
      end
   end

endmodule

[hdl/dice_sum_ways_count.sv]
// Counts the ordered outcomes of a throw of req_dice dice with req_faces faces that add up
// to req_target. Targets below the dice count or above faces times dice answer 0, targets
// on either bound answer 1, and other items with sizes beyond the parameters answer 0;
// these go from acceptance to the done state with their result registered. Other items
// build the count one die at a time: each die is one pass over the row memory, with a
// chain of MAX_FACES cells holding the sliding window of the previous row, and the result
// is registered at the end of the last pass; the largest target that builds a table is
// 255 at the default sizes. One transaction is in the engine at a time; a finished
// result waits in the output register while the next transaction is accepted. No
// clearing pass is needed after reset.
`include "assert_macros.svh"

module dice_sum_ways_count #(
   parameter int MAX_FACES = dsw_pkg::MAX_FACES_DEFAULT,
   parameter int MAX_DICE  = dsw_pkg::MAX_DICE_DEFAULT,
   parameter int MAX_SUM   = dsw_pkg::MAX_SUM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsw_pkg::FACES_W-1:0]   req_faces,
   input  logic [dsw_pkg::DICE_W-1:0]    req_dice,
   input  logic [dsw_pkg::TARGET_W-1:0]  req_target,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsw_pkg::WAYS_W-1:0]    rsp_ways
);

   localparam int FW    = $clog2(MAX_FACES);
   localparam int DIE_W = $clog2(MAX_DICE + 1);
   localparam int SUM_W = $clog2(MAX_SUM + 1);

   dsw_pkg::state_type state_ff, state_in;

   logic [dsw_pkg::FACES_W-1:0] faces_ff, faces_in;
   logic [DIE_W-1:0]            dice_ff, dice_in;
   logic [DIE_W-1:0]            die_ff, die_in;
   logic [SUM_W-1:0]            tgt_ff, tgt_in;
   logic [SUM_W-1:0]            r_ff, r_in;
   logic                        p_vld_ff, p_vld_in;
   logic [SUM_W-1:0]            p_idx_ff, p_idx_in;
   logic [dsw_pkg::WAYS_W-1:0]  res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dsw_pkg::WAYS_W-1:0]  rsp_ways_ff, rsp_ways_in;
   logic [dsw_pkg::WAYS_W-1:0]  rd_data_ff;

   logic [dsw_pkg::WAYS_W-1:0]  row_mem [MAX_SUM+1];

   logic [dsw_pkg::TOP_W-1:0]   top_sum;
   logic [dsw_pkg::TOP_W-1:0]   tgt_ext;
   logic [dsw_pkg::TOP_W-1:0]   dice_ext;
   logic                        outside, on_bound, too_big;
   logic                        first_die;
   logic [dsw_pkg::WAYS_W-1:0]  win_data;
   logic [dsw_pkg::WAYS_W-1:0]  acc_next;
   logic [FW-1:0]               tap_sel;
   logic [SUM_W-1:0]            wr_addr;
   dsw_pkg::win_ctrl_type       win_ctrl;

   // classify the incoming transaction
   assign top_sum  = dsw_pkg::TOP_W'(req_faces) * dsw_pkg::TOP_W'(req_dice);
   assign tgt_ext  = dsw_pkg::TOP_W'(req_target);
   assign dice_ext = dsw_pkg::TOP_W'(req_dice);
   assign outside  = (tgt_ext < dice_ext) || (tgt_ext > top_sum);
   assign on_bound = (tgt_ext == dice_ext) || (tgt_ext == top_sum);
   assign too_big  = (32'(req_faces) > MAX_FACES) || (32'(req_dice) > MAX_DICE)
                     || (32'(req_target) > MAX_SUM);

   // row zero is a single one at sum zero; entry zero of later rows is zero
   assign first_die = (die_ff == DIE_W'(1));
   always_comb begin
      if (p_idx_ff == '0) begin
         win_data = first_die ? dsw_pkg::WAYS_W'(1) : '0;
      end else begin
         win_data = first_die ? '0 : rd_data_ff;
      end
   end

   assign tap_sel           = FW'(faces_ff - dsw_pkg::FACES_W'(1));
   assign win_ctrl.shift    = p_vld_ff;
   assign win_ctrl.first    = (p_idx_ff == '0);
   assign win_ctrl.tap_zero = (32'(p_idx_ff) < 32'(faces_ff));

   dsw_window #(
      .MAX_FACES (MAX_FACES)
   ) u_window (
      .clock    (clock),
      .ctrl     (win_ctrl),
      .tap_sel  (tap_sel),
      .data     (win_data),
      .acc_next (acc_next)
   );

   assign wr_addr = p_idx_ff + SUM_W'(1);

   always_ff @(posedge clock) begin
      if (p_vld_ff) begin
         row_mem[wr_addr] <= acc_next;
      end
      rd_data_ff <= row_mem[r_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsw_pkg::S_IDLE;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         die_ff       <= '0;
         r_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         die_ff       <= die_in;
         r_ff         <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      faces_ff    <= faces_in;
      dice_ff     <= dice_in;
      tgt_ff      <= tgt_in;
      p_idx_ff    <= p_idx_in;
      res_ff      <= res_in;
      rsp_ways_ff <= rsp_ways_in;
   end

   always_comb begin
      state_in     = state_ff;
      faces_in     = faces_ff;
      dice_in      = dice_ff;
      tgt_in       = tgt_ff;
      die_in       = die_ff;
      r_in         = r_ff;
      p_vld_in     = 1'b0;
      p_idx_in     = r_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ways_in  = rsp_ways_ff;
      req_stall    = (state_ff != dsw_pkg::S_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         dsw_pkg::S_IDLE: begin
            if (req_valid) begin
               faces_in = req_faces;
               dice_in  = DIE_W'(req_dice);
               tgt_in   = SUM_W'(req_target);
               if (outside) begin
                  res_in   = '0;
                  state_in = dsw_pkg::S_DONE;
               end else if (on_bound) begin
                  res_in   = dsw_pkg::WAYS_W'(1);
                  state_in = dsw_pkg::S_DONE;
               end else if (too_big) begin
                  res_in   = '0;
                  state_in = dsw_pkg::S_DONE;
               end else begin
                  die_in   = DIE_W'(1);
                  r_in     = '0;
                  state_in = dsw_pkg::S_RUN;
               end
            end
         end
         dsw_pkg::S_RUN: begin
            if (r_ff == tgt_ff) begin
               // last entry of this row leaves the window now
               if (die_ff == dice_ff) begin
                  res_in   = acc_next;
                  state_in = dsw_pkg::S_DONE;
               end else begin
                  die_in = die_ff + DIE_W'(1);
                  r_in   = '0;
               end
            end else begin
               p_vld_in = 1'b1;
               r_in     = r_ff + SUM_W'(1);
            end
         end
         dsw_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ways_in  = res_ff;
               state_in     = dsw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dsw_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ways  = rsp_ways_ff;

   `DSW_ASSERT_NOW(a_proc_in_run, clock, reset, p_vld_ff, state_ff == dsw_pkg::S_RUN)
   `DSW_ASSERT_NOW(a_idx_in_row, clock, reset, state_ff == dsw_pkg::S_RUN, r_ff <= tgt_ff)
   `DSW_ASSERT_NOW(a_die_bound, clock, reset, state_ff == dsw_pkg::S_RUN,
                   (die_ff != '0) && (die_ff <= dice_ff))
   `DSW_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall,
                    state_ff != dsw_pkg::S_IDLE)

endmodule
